// ----- rtl/core/rbfk_pkg.sv -----
`default_nettype none

package rbfk_pkg;

    // Store geometry.
    localparam int MAX_POINTS = 64;
    localparam int MAX_DIMS   = 8;

    localparam int PIDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CNT_W  = $clog2(MAX_POINTS + 1);
    localparam int DIM_W  = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
    localparam int SUM_W  = 53 + $clog2(MAX_DIMS);

    // Field widths.
    localparam int COORD_W = 24;
    localparam int VAL_W   = 24;
    localparam int IDX_W   = 6;
    localparam int NDIM_W  = 4;

    // Configuration register indexes.
    localparam logic [1:0] REG_SIGNAL_VARIANCE = 2'd0;
    localparam logic [1:0] REG_INV_TWO_LEN_SQ  = 2'd1;
    localparam logic [1:0] REG_NUM_DIMS        = 2'd2;

    localparam logic [16:0] LOG2E_Q16  = 17'd94548;
    localparam logic [13:0] NUGGET_Q16 = 14'd6554;

    // Per-entry bookkeeping that travels with a column through the pipeline.
    typedef struct packed {
        logic              vld;
        logic [PIDX_W-1:0] row;
        logic [PIDX_W-1:0] col;
        logic              last;
        logic              full;
    } meta_t;

    typedef struct packed {
        meta_t            m;
        logic [SUM_W-1:0] sum;
    } tok_t;

    typedef struct packed {
        meta_t            m;
        logic [VAL_W-1:0] cov;
    } res_t;

    // 2^(-k/16) in Q.24 for k = 0 .. 16.
    function automatic logic [24:0] pow2_tab(input logic [4:0] k);
        logic [24:0] v;
        unique case (k)
            5'd0:    v = 25'd16777216;
            5'd1:    v = 25'd16065917;
            5'd2:    v = 25'd15384775;
            5'd3:    v = 25'd14732511;
            5'd4:    v = 25'd14107901;
            5'd5:    v = 25'd13509772;
            5'd6:    v = 25'd12937002;
            5'd7:    v = 25'd12388516;
            5'd8:    v = 25'd11863283;
            5'd9:    v = 25'd11360319;
            5'd10:   v = 25'd10878679;
            5'd11:   v = 25'd10417458;
            5'd12:   v = 25'd9975792;
            5'd13:   v = 25'd9552851;
            5'd14:   v = 25'd9147842;
            5'd15:   v = 25'd8760003;
            default: v = 25'd8388608;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/rbfk_cell.sv -----
`default_nettype none

// One coordinate lane: holds one coordinate of every stored point and of
// the current point, adds its squared difference to the passing sum.
module rbfk_cell
    import rbfk_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                adv,
    input  wire logic                wr_en,
    input  wire logic                cur_we,
    input  wire logic [PIDX_W-1:0]   wr_addr,
    input  wire logic [COORD_W-1:0]  wr_data,
    input  wire logic                active,
    input  wire tok_t                tok_in,
    output tok_t                     tok_out
);

    logic [COORD_W-1:0] bank [MAX_POINTS];
    logic [COORD_W-1:0] rd_reg;
    logic [COORD_W-1:0] cur_reg;
    tok_t               tok_a_reg;
    tok_t               tok_b_reg;
    logic [49:0]        sq_reg;
    logic signed [24:0] diff;
    logic signed [49:0] sq_full;

    // Coordinate bank, read one column per cycle while the pipeline advances.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            bank[wr_addr] <= wr_data;
        end
        if (adv)
        begin
            rd_reg <= bank[tok_in.m.col];
        end
    end

    // Coordinate of the point being completed.
    always_ff @(posedge clk)
    begin
        if (cur_we)
        begin
            cur_reg <= wr_data;
        end
    end

    assign diff    = $signed({rd_reg[COORD_W-1], rd_reg}) - $signed({cur_reg[COORD_W-1], cur_reg});
    assign sq_full = diff * diff;

    // Two stages: bank read, then square.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_a_reg <= '0;
            tok_b_reg <= '0;
            sq_reg    <= '0;
        end
        else if (adv)
        begin
            tok_a_reg <= tok_in;
            tok_b_reg <= tok_a_reg;
            sq_reg    <= active ? 50'(unsigned'(sq_full)) : 50'd0;
        end
    end

    // Hand the grown sum to the next lane.
    always_comb
    begin
        tok_out     = tok_b_reg;
        tok_out.sum = tok_b_reg.sum + SUM_W'(sq_reg);
    end

endmodule

`default_nettype wire

// ----- rtl/core/rbfk_kern.sv -----
`default_nettype none

// Turns a squared distance into a saturated covariance entry.
module rbfk_kern
    import rbfk_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              adv,
    input  wire tok_t              tok_in,
    input  wire logic [VAL_W-1:0]  sig_var,
    input  wire logic [VAL_W-1:0]  inv_len,
    output res_t                   res
);

    localparam int D16_W = SUM_W - 16;

    meta_t        m1_reg, m2_reg, m3_reg, m4_reg, m5_reg;
    logic [41:0]  ph_reg, pl_reg;
    logic         big_reg;
    logic [36:0]  y_reg;
    logic         z2_reg, z3_reg;
    logic [24:0]  hi_reg;
    logic [36:0]  dp_reg;
    logic [4:0]   n_reg;
    logic [24:0]  e_reg;
    logic [48:0]  prod_reg;
    logic [37:0]  dg_reg;
    res_t         res_reg;

    logic [D16_W-1:0] d16;
    logic [60:0]      p;
    logic [20:0]      y21;
    logic [24:0]      t_hi, t_lo;
    logic [24:0]      v;
    logic [24:0]      off_val;
    logic [25:0]      diag_val;
    logic [VAL_W-1:0] cov;

    assign d16  = tok_in.sum[SUM_W-1:16];
    assign p    = 61'({ph_reg, 18'd0}) + 61'(pl_reg);
    assign y21  = y_reg[36:16];
    assign t_hi = pow2_tab({1'b0, y21[15:12]});
    assign t_lo = pow2_tab(5'({1'b0, y21[15:12]}) + 5'd1);
    assign v    = hi_reg - 25'((dp_reg + 37'd2048) >> 12);

    // Off-diagonal rounding, diagonal nugget, saturation.
    assign off_val  = 25'((prod_reg + 49'h800000) >> 24);
    assign diag_val = {2'b00, sig_var} + 26'((dg_reg + 38'd32768) >> 16);
    always_comb
    begin
        if (m5_reg.last)
        begin
            cov = (|diag_val[25:24]) ? {VAL_W{1'b1}} : diag_val[VAL_W-1:0];
        end
        else
        begin
            cov = off_val[24] ? {VAL_W{1'b1}} : off_val[VAL_W-1:0];
        end
    end

    // Six stages: scale split in halves, log2 e, table step, shift, sigma, output.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m1_reg  <= '0;
            m2_reg  <= '0;
            m3_reg  <= '0;
            m4_reg  <= '0;
            m5_reg  <= '0;
            res_reg <= '0;
        end
        else if (adv)
        begin
            m1_reg     <= tok_in.m;
            m2_reg     <= m1_reg;
            m3_reg     <= m2_reg;
            m4_reg     <= m3_reg;
            m5_reg     <= m4_reg;
            res_reg.m  <= m5_reg;
            res_reg.cov <= cov;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ph_reg   <= 42'(d16[35:18] * inv_len);
            pl_reg   <= 42'(d16[17:0] * inv_len);
            big_reg  <= |d16[D16_W-1:36];
            y_reg    <= 37'(p[35:16] * LOG2E_Q16);
            z2_reg   <= big_reg | (|p[60:36]);
            hi_reg   <= t_hi;
            dp_reg   <= 37'((t_hi - t_lo) * y21[11:0]);
            n_reg    <= y21[20:16];
            z3_reg   <= z2_reg;
            e_reg    <= z3_reg ? 25'd0 : (v >> n_reg);
            prod_reg <= 49'(sig_var * e_reg);
            dg_reg   <= 38'(sig_var * NUGGET_Q16);
        end
    end

    assign res = res_reg;

endmodule

`default_nettype wire

// ----- rtl/core/rbf_kernel_covariance_rows.sv -----
`default_nettype none

// Channel  Signals                                      Direction
// in       in_valid/in_ready, coord, new_set            into block
// out      out_valid/out_ready, row_index, col_index,   out of block
//          cov_value, row_last, store_full
// cfg      cfg_valid/cfg_ready, cfg_index, cfg_data     into block
//
// Each coordinate is one input transfer. A completed point r, unless the store
// is full, yields r + 1 entries through the lane chain and the exponent
// pipeline, one per cycle while the output is not stalled. The next coordinate
// is taken once the row has drained. Reset empties the store and restores the
// register defaults. A stall on the output freezes the whole pipeline.
module rbf_kernel_covariance_rows
    import rbfk_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic [COORD_W-1:0]  coord,
    input  wire logic                new_set,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic [IDX_W-1:0]         row_index,
    output logic [IDX_W-1:0]         col_index,
    output logic [VAL_W-1:0]         cov_value,
    output logic                     row_last,
    output logic                     store_full,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [1:0]          cfg_index,
    input  wire logic [31:0]         cfg_data
);

    logic [VAL_W-1:0]  sig_reg;
    logic [VAL_W-1:0]  inv_reg;
    logic [NDIM_W-1:0] ndim_reg;

    logic [CNT_W-1:0]  count_reg, count_next;
    logic [DIM_W-1:0]  pos_reg, pos_next;
    logic              busy_reg, busy_next;
    logic [PIDX_W-1:0] row_reg, row_next;
    logic [PIDX_W-1:0] col_reg, col_next;
    logic              rfull_reg, rfull_next;
    logic [7:0]        infl_reg, infl_next;

    logic              in_xfer, out_xfer, adv, issue;
    logic [CNT_W-1:0]  cnt;
    logic [DIM_W-1:0]  pos;
    logic              full;
    logic [4:0]        dims;
    tok_t              chain [MAX_DIMS+1];
    res_t              res;

    assign cfg_ready = 1'b1;
    assign in_ready  = !busy_reg && (infl_reg == 8'd0);
    assign in_xfer   = in_valid && in_ready;
    assign adv       = !res.m.vld || out_ready;
    assign out_xfer  = res.m.vld && out_ready;
    assign issue     = busy_reg && adv;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sig_reg  <= VAL_W'(65536);
            inv_reg  <= VAL_W'(32768);
            ndim_reg <= NDIM_W'(1);
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_SIGNAL_VARIANCE: sig_reg  <= cfg_data[VAL_W-1:0];
                REG_INV_TWO_LEN_SQ:  inv_reg  <= cfg_data[VAL_W-1:0];
                REG_NUM_DIMS:        ndim_reg <= cfg_data[NDIM_W-1:0];
                default:             ;
            endcase
        end
    end

    // Clamp the dimension count into 1 .. MAX_DIMS.
    always_comb
    begin
        priority if (ndim_reg == '0)
            dims = 5'd1;
        else if (5'(ndim_reg) > 5'(MAX_DIMS))
            dims = 5'(MAX_DIMS);
        else
            dims = 5'(ndim_reg);
    end

    assign cnt  = new_set ? '0 : count_reg;
    assign pos  = new_set ? '0 : pos_reg;
    assign full = cnt >= CNT_W'(MAX_POINTS);

    // Point sequencer and column issue.
    always_comb
    begin
        count_next = count_reg;
        pos_next   = pos_reg;
        busy_next  = busy_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        rfull_next = rfull_reg;
        infl_next  = infl_reg + 8'(issue) - 8'(out_xfer);
        if (in_xfer)
        begin
            count_next = cnt;
            if (5'(pos) + 5'd1 < dims)
            begin
                pos_next = pos + DIM_W'(1);
            end
            else
            begin
                pos_next = '0;
                if (!full)
                begin
                    count_next = cnt + CNT_W'(1);
                    busy_next  = 1'b1;
                    row_next   = cnt[PIDX_W-1:0];
                    col_next   = '0;
                    rfull_next = (cnt + CNT_W'(1)) >= CNT_W'(MAX_POINTS);
                end
            end
        end
        else if (issue)
        begin
            if (col_reg == row_reg)
                busy_next = 1'b0;
            else
                col_next = col_reg + PIDX_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            pos_reg   <= '0;
            busy_reg  <= 1'b0;
            row_reg   <= '0;
            col_reg   <= '0;
            rfull_reg <= 1'b0;
            infl_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            pos_reg   <= pos_next;
            busy_reg  <= busy_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
            rfull_reg <= rfull_next;
            infl_reg  <= infl_next;
        end
    end

    // Head of the lane chain.
    always_comb
    begin
        chain[0]        = '0;
        chain[0].m.vld  = issue;
        chain[0].m.row  = row_reg;
        chain[0].m.col  = col_reg;
        chain[0].m.last = (col_reg == row_reg);
        chain[0].m.full = rfull_reg;
    end

    for (genvar k = 0; k < MAX_DIMS; k++)
    begin : g_lane
        rbfk_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .adv     (adv),
            .wr_en   (in_xfer && !full && (pos == DIM_W'(k))),
            .cur_we  (in_xfer && (pos == DIM_W'(k))),
            .wr_addr (cnt[PIDX_W-1:0]),
            .wr_data (coord),
            .active  (5'(k) < dims),
            .tok_in  (chain[k]),
            .tok_out (chain[k+1])
        );
    end

    rbfk_kern u_kern (
        .clk     (clk),
        .rst_n   (rst_n),
        .adv     (adv),
        .tok_in  (chain[MAX_DIMS]),
        .sig_var (sig_reg),
        .inv_len (inv_reg),
        .res     (res)
    );

    assign out_valid  = res.m.vld;
    assign row_index  = IDX_W'(res.m.row);
    assign col_index  = IDX_W'(res.m.col);
    assign cov_value  = res.cov;
    assign row_last   = res.m.last;
    assign store_full = res.m.full;

endmodule

`default_nettype wire
